/* rtl/core/macd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD package
// Shared widths, register indexes, reset values and status types.
// ----------------------------------------------------------------------------
package macd_pkg;

   localparam int PRICE_W    = 32;
   localparam int PERIOD_W   = 8;
   localparam int GAIN_W     = 16;
   localparam int AVG_W      = 32;
   localparam int HIST_W     = 40;
   localparam int DIVISOR_W  = PERIOD_W + 1;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 3 * AVG_W + HIST_W;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_PERIOD  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PERIOD   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_PERIOD = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIST_GAIN     = 8'd3;

   localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST  = 8'd12;
   localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST   = 8'd26;
   localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;
   localparam logic [GAIN_W-1:0]   HIST_GAIN_RST     = 16'd25559;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/core/macd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module macd_div #(
   parameter int NW = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [NW-1:0]                      dividend,
   input  logic [macd_pkg::DIVISOR_W-1:0]     divisor,
   output logic [NW-1:0]                      quotient,
   output macd_pkg::div_status_type           status
);

   localparam int DW = macd_pkg::DIVISOR_W;
   localparam int CW = $clog2(NW);

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic [DW:0]   trial;
   logic          fits;

   assign shifted = {rem_ff, quo_ff[NW-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(NW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NW-2:0], fits};
         rem_in = fits ? trial[DW-1:0] : shifted[DW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

/* rtl/core/macd_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD shared multiplier
// Signed by unsigned product with a registered result.
// ----------------------------------------------------------------------------
module macd_mul #(
   parameter int AW = 43,
   parameter int BW = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    a,
   input  logic [BW-1:0]           b,
   output logic signed [AW+BW:0]   prod
);

   logic signed [AW+BW:0] prod_ff;
   logic signed [AW+BW:0] prod_in;

   assign prod_in = a * $signed({1'b0, b});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/core/macd_indicator_stream.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MACD indicator stream
// Fast, slow and signal EMAs of a price stream with the MACD histogram.
// ----------------------------------------------------------------------------
// req_ carries one close price word (tuser flags the first sample of a
// series); rsp_ returns one word per request: fast EMA, slow EMA, DEA and
// histogram. csr_ writes the three periods and the gain; it is always ready.
// The user must write csr_ only while the block is idle; the block does not enforce it.
// A request is taken only in the idle state. Each of the three EMAs runs a
// multiply, a numerator add and a bit-serial division of F+24 steps in turn,
// then the histogram multiply runs and the word goes to the output register.
// A new word is taken only after the last one's result has been loaded.
// A first-sample word clears the averages and goes straight to the
// histogram state. The result sits in an output register;
// the block waits in its last state while the receiver stalls and returns
// to idle as the result is loaded. Reset restores the default periods and
// gain and zeroes all three averages.
// ----------------------------------------------------------------------------
module macd_indicator_stream #(
   parameter int STATE_FRAC_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [macd_pkg::PRICE_W-1:0]         req_tdata,   // closing price
   input  logic                                 req_tuser,   // first_sample
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // fast_average, slow_average, signal_line, histogram
   output logic [macd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [macd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [macd_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int F   = STATE_FRAC_BITS;
   localparam int EW  = 16 + F;
   localparam int SW  = EW + 1;
   localparam int AW  = F + 19;
   localparam int GW  = macd_pkg::GAIN_W;
   localparam int PW  = AW + GW + 1;
   localparam int NSW = F + 26;
   localparam int NW  = F + 24;
   localparam int OSH = F - 16;
   localparam int GSH = F - 4;
   localparam int PRW = macd_pkg::PERIOD_W;
   localparam int AVW = macd_pkg::AVG_W;
   localparam int HW  = macd_pkg::HIST_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_NUM  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_HIST = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   localparam logic [1:0] SEL_FAST = 2'd0;
   localparam logic [1:0] SEL_SLOW = 2'd1;
   localparam logic [1:0] SEL_DEA  = 2'd2;

   logic [2:0]              state_ff, state_in;
   logic [1:0]              sel_ff, sel_in;
   logic [PRW-1:0]          short_ff, long_ff, signal_ff;
   logic [GW-1:0]           gain_ff;
   logic [EW-1:0]           fast_ff, fast_in;
   logic [EW-1:0]           slow_ff, slow_in;
   logic signed [SW-1:0]    dea_ff, dea_in;
   logic signed [SW-1:0]    dif_ff, dif_in;
   logic [EW-1:0]           price_ff, price_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [macd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                    req_take;
   logic                    rsp_free;
   logic [PRW-1:0]          per, eff, nm1;
   logic [macd_pkg::DIVISOR_W-1:0] np1;
   logic signed [SW-1:0]    prev_ext, x_ext;
   logic signed [AW-1:0]    mul_a;
   logic [GW-1:0]           mul_b;
   logic                    mul_en;
   logic signed [PW-1:0]    prod;
   logic signed [NSW-1:0]   num;
   logic [NW-1:0]           dividend;
   logic                    div_start;
   logic [NW-1:0]           quotient;
   macd_pkg::div_status_type div_stat;
   logic signed [SW-1:0]    q_res;
   logic signed [SW-1:0]    dea_sh;
   logic signed [PW-1:0]    hist_sh;
   logic [AVW-1:0]          sig_sat;
   logic [HW-1:0]           hist_sat;
   logic                    sig_ovf, hist_ovf;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= macd_pkg::SHORT_PERIOD_RST;
         long_ff   <= macd_pkg::LONG_PERIOD_RST;
         signal_ff <= macd_pkg::SIGNAL_PERIOD_RST;
         gain_ff   <= macd_pkg::HIST_GAIN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            macd_pkg::CSR_SHORT_PERIOD:  short_ff  <= csr_data[PRW-1:0];
            macd_pkg::CSR_LONG_PERIOD:   long_ff   <= csr_data[PRW-1:0];
            macd_pkg::CSR_SIGNAL_PERIOD: signal_ff <= csr_data[PRW-1:0];
            macd_pkg::CSR_HIST_GAIN:     gain_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // operand selection
   always_comb begin
      case (sel_ff)
         SEL_FAST: begin
            per      = short_ff;
            prev_ext = $signed({1'b0, fast_ff});
            x_ext    = $signed({1'b0, price_ff});
         end
         SEL_SLOW: begin
            per      = long_ff;
            prev_ext = $signed({1'b0, slow_ff});
            x_ext    = $signed({1'b0, price_ff});
         end
         default: begin
            per      = signal_ff;
            prev_ext = dea_ff;
            x_ext    = dif_ff;
         end
      endcase
   end

   assign eff = (per == '0) ? PRW'(1) : per;
   assign nm1 = eff - 1'b1;
   assign np1 = {1'b0, eff} + 1'b1;

   always_comb begin
      if (state_ff == ST_HIST) begin
         mul_a = $signed({{(AW-SW){dif_ff[SW-1]}}, dif_ff})
               - $signed({{(AW-SW){dea_ff[SW-1]}}, dea_ff});
         mul_b = gain_ff;
      end else begin
         mul_a = $signed({{(AW-SW){prev_ext[SW-1]}}, prev_ext});
         mul_b = {{(GW-PRW){1'b0}}, nm1};
      end
   end

   assign mul_en = (state_ff == ST_MUL) || (state_ff == ST_HIST);

   macd_mul #(
      .AW (AW),
      .BW (GW)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // 2*x + (N-1)*prev; floor division of a negative numerator via complement
   assign num = $signed({{(NSW-SW-1){x_ext[SW-1]}}, x_ext, 1'b0}) + prod[NSW-1:0];
   assign dividend = num[NSW-1] ? ~num[NW-1:0] : num[NW-1:0];
   assign div_start = (state_ff == ST_NUM);

   macd_div #(
      .NW (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (np1),
      .quotient (quotient),
      .status   (div_stat)
   );

   assign q_res = neg_ff ? ~$signed(quotient[SW-1:0]) : $signed(quotient[SW-1:0]);

   // output scaling and saturation
   assign dea_sh  = dea_ff >>> OSH;
   assign hist_sh = prod >>> GSH;
   assign sig_ovf  = (|dea_sh[SW-1:AVW-1]) && !(&dea_sh[SW-1:AVW-1]);
   assign hist_ovf = (|hist_sh[PW-1:HW-1]) && !(&hist_sh[PW-1:HW-1]);
   assign sig_sat  = sig_ovf ? {dea_sh[SW-1], {(AVW-1){~dea_sh[SW-1]}}}
                             : dea_sh[AVW-1:0];
   assign hist_sat = hist_ovf ? {hist_sh[PW-1], {(HW-1){~hist_sh[PW-1]}}}
                              : hist_sh[HW-1:0];

   assign req_take = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      dea_in       = dea_ff;
      dif_in       = dif_ff;
      price_in     = price_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser) begin
                  fast_in  = '0;
                  slow_in  = '0;
                  dea_in   = '0;
                  dif_in   = '0;
                  state_in = ST_HIST;
               end else begin
                  price_in = {req_tdata, {OSH{1'b0}}};
                  sel_in   = SEL_FAST;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_NUM;
         end
         ST_NUM: begin
            neg_in   = num[NSW-1];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               case (sel_ff)
                  SEL_FAST: begin
                     fast_in  = q_res[EW-1:0];
                     sel_in   = SEL_SLOW;
                     state_in = ST_MUL;
                  end
                  SEL_SLOW: begin
                     slow_in  = q_res[EW-1:0];
                     dif_in   = $signed({1'b0, fast_ff}) - $signed({1'b0, q_res[EW-1:0]});
                     sel_in   = SEL_DEA;
                     state_in = ST_MUL;
                  end
                  default: begin
                     dea_in   = q_res;
                     state_in = ST_HIST;
                  end
               endcase
            end
         end
         ST_HIST: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {hist_sat, sig_sat, slow_ff[EW-1:OSH], fast_ff[EW-1:OSH]};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_FAST;
         rsp_valid_ff <= 1'b0;
         fast_ff      <= '0;
         slow_ff      <= '0;
         dea_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         dea_ff       <= dea_in;
      end
   end

   always_ff @(posedge clock) begin
      dif_ff      <= dif_in;
      price_ff    <= price_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_div_busy_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == ST_DIV))
      else $error("divider busy outside the divide state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider done outside the divide state");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_OUT))
      else $error("result overwritten while the receiver stalls");

   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tuser) |=> (fast_ff == '0 && slow_ff == '0 && dea_ff == '0))
      else $error("first sample did not clear the averages");

   a_sel_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (sel_ff == SEL_FAST || sel_ff == SEL_SLOW
                                || sel_ff == SEL_DEA))
      else $error("no average selected during division");

endmodule
